// ----- rtl/fccs_pkg.sv -----
package fccs_pkg;

	localparam int FRAC_BITS_DEF = 8;
	localparam int WORD_W        = 16;
	localparam int CRC_W         = 8;
	localparam int FLOW_W        = 25;
	localparam int CFG_IDX_W     = 2;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [8:0]  CRC_POLY = 9'h131;
	localparam logic [7:0]  CRC_TOP  = 8'h80;
	localparam logic [23:0] FLOW_MAX = 24'hFFFFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FLOW_OFFSET = 2'd0,
		REG_FLOW_SCALE  = 2'd1
	} cfg_reg_t;

	// classified frame, handed from front to back
	typedef struct packed {
		logic [WORD_W-1:0] mag;
		logic              neg;
		logic              ok;
		logic              zero;
		logic [CRC_W-1:0]  crc;
	} qent_t;

	// result beat, flow in the low bits
	typedef struct packed {
		logic [CRC_W-1:0]         crc;
		logic                     scale_error;
		logic                     crc_ok;
		logic signed [FLOW_W-1:0] flow;
	} result_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			if ((c & CRC_TOP) != 8'h00) begin
				c = (c << 1) ^ CRC_POLY[7:0];
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- rtl/flow_frame_crc_check_and_scale_unit.sv -----
// Path: an accepted input beat is registered in the front stage and queued;
//   a good frame is then divided bit-serially in the back end (DW = 16 + FRAC_BITS,
//   24 by default) and a rejected one skips the divide. The back end takes a new
//   frame only once its last result is in the output register. Input and queue decouple it.
// Reset (arst_n low, asynchronous): queue and handshakes clear, held flow is 0,
//   flow_offset is 0, flow_scale is 1.
module flow_frame_crc_check_and_scale_unit
	import fccs_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [23:0]          s_axis_tdata,  // data_word[15:0], crc_byte[23:16]
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [39:0]          m_axis_tdata,  // flow_value[24:0], crc_ok[25],
	                                            // scale_error[26], computed_crc[34:27]
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_wdata
);

	logic [15:0] flow_offset_q;
	logic [15:0] flow_scale_q;
	logic        push;
	logic        full;
	logic        pop;
	logic        q_not_empty;
	qent_t       push_ent;
	qent_t       pop_ent;
	result_t     res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flow_offset_q <= 16'd0;
			flow_scale_q  <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FLOW_OFFSET: flow_offset_q <= cfg_wdata;
				REG_FLOW_SCALE:  flow_scale_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	fccs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.data_word   (s_axis_tdata[15:0]),
		.crc_byte    (s_axis_tdata[23:16]),
		.flow_offset (flow_offset_q),
		.flow_scale  (flow_scale_q),
		.push        (push),
		.full        (full),
		.push_ent    (push_ent)
	);

	fccs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ent  (push_ent),
		.full      (full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.pop_ent   (pop_ent)
	);

	fccs_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.flow_scale  (flow_scale_q),
		.q_not_empty (q_not_empty),
		.q_ent       (pop_ent),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (res)
	);

	assign m_axis_tdata = {5'd0, res};

endmodule

// ----- rtl/fccs_front.sv -----
module fccs_front
	import fccs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [WORD_W-1:0] data_word,
	input  logic [CRC_W-1:0]  crc_byte,
	input  logic [15:0]       flow_offset,
	input  logic [15:0]       flow_scale,
	output logic              push,
	input  logic              full,
	output qent_t             push_ent
);

	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic [CRC_W-1:0]  rx_s1;
	logic [CRC_W-1:0]  crc_hi_s1;
	logic [CRC_W-1:0]  crc_full;
	logic [16:0]       diff;
	logic [16:0]       diff_neg;

	assign push     = valid_s1 && !full;
	assign in_ready = !valid_s1 || !full;

	// high byte is folded in on the way into the stage, low byte after it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1   <= data_word;
			rx_s1     <= crc_byte;
			crc_hi_s1 <= crc8_byte(8'h00, data_word[15:8]);
		end
	end

	always_comb begin
		crc_full = crc8_byte(crc_hi_s1, word_s1[7:0]);
		diff     = {1'b0, word_s1} - {1'b0, flow_offset};
		diff_neg = 17'(-diff);
		push_ent.mag  = diff[16] ? diff_neg[15:0] : diff[15:0];
		push_ent.neg  = diff[16];
		push_ent.ok   = (crc_full == rx_s1);
		push_ent.zero = (flow_scale == 16'h0000);
		push_ent.crc  = crc_full;
	end

endmodule

// ----- rtl/fccs_queue.sv -----
module fccs_queue
	import fccs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t push_ent,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output qent_t pop_ent
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	qent_t         mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_ent   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

// ----- rtl/fccs_back.sv -----
module fccs_back
	import fccs_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [15:0] flow_scale,
	input  logic       q_not_empty,
	input  qent_t      q_ent,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output result_t    out_data
);

	localparam int DW = WORD_W + FRAC_BITS;
	localparam int CW = $clog2(DW);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_OUT  = 3'b100
	} state_t;

	state_t               state_q;
	qent_t                ent_q;
	logic [DW-1:0]        dq_q;
	logic [15:0]          rem_q;
	logic [CW-1:0]        cnt_q;
	logic signed [FLOW_W-1:0] last_flow_q;
	logic                 out_valid_q;
	result_t              out_q;

	logic [16:0]          trial;
	logic                 ge;
	logic [16:0]          trial_sub;
	logic [31:0]          q_ext;
	logic [23:0]          mag24;
	logic [FLOW_W-1:0]    mag25;
	logic [FLOW_W-1:0]    flow_new;
	logic                 load;

	assign pop       = (state_q == S_IDLE) && q_not_empty;
	assign load      = (state_q == S_OUT) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// restoring divide, one quotient bit per cycle
	always_comb begin
		trial     = {rem_q, dq_q[DW-1]};
		ge        = (trial >= {1'b0, flow_scale});
		trial_sub = trial - {1'b0, flow_scale};
		q_ext     = 32'(dq_q);
		mag24     = (q_ext > 32'(FLOW_MAX)) ? FLOW_MAX : q_ext[23:0];
		mag25     = {1'b0, mag24};
		flow_new  = ent_q.neg ? FLOW_W'(-mag25) : mag25;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_flow_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_not_empty) begin
						state_q <= (q_ent.ok && !q_ent.zero) ? S_DIV : S_OUT;
					end
				end
				S_DIV: begin
					if (cnt_q == CW'(DW - 1)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
				if (ent_q.ok && !ent_q.zero) begin
					last_flow_q <= flow_new;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= q_ent;
			dq_q  <= DW'(q_ent.mag) << FRAC_BITS;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (state_q == S_DIV) begin
			dq_q  <= {dq_q[DW-2:0], ge};
			rem_q <= ge ? trial_sub[15:0] : trial[15:0];
			cnt_q <= cnt_q + 1'b1;
		end
		if (load) begin
			out_q.crc         <= ent_q.crc;
			out_q.scale_error <= ent_q.zero;
			out_q.crc_ok      <= ent_q.ok;
			out_q.flow        <= (ent_q.ok && !ent_q.zero) ? flow_new : last_flow_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_out_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.flow == last_flow_q) else $error("shown flow differs from held flow");
	a_div_only_good: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> ent_q.ok && !ent_q.zero) else $error("divide on rejected frame");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < flow_scale) else $error("remainder not below divisor");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> cnt_q <= CW'(DW - 1)) else $error("divide ran too long");
`endif

endmodule

// ----- tb/flow_frame_crc_check_and_scale_unit_tb.sv -----
`timescale 1ns / 100ps

module flow_frame_crc_check_and_scale_unit_tb;

	import fccs_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
	localparam int PHASES          = 10;
	localparam int FRAMES_PER_PHASE = 192;
	localparam int IDLE_PCT        = 28;

	class flow_frame_scoreboard;
		logic [15:0]              offset_reg;
		logic [15:0]              scale_reg;
		logic signed [FLOW_W-1:0] held_flow;
		result_t                  results_due[$];
		int errors;
		int checked;
		int converted;
		int crc_rejects;
		int zero_scale;
		int negatives;

		function new();
			offset_reg = 16'd0;
			scale_reg  = 16'd1;
			held_flow  = '0;
			errors = 0;
			checked = 0;
			converted = 0;
			crc_rejects = 0;
			zero_scale = 0;
			negatives = 0;
		endfunction

		// CRC-8, poly 0x31, MSB first, init 0, fed one bit at a time
		static function logic [7:0] crc8_of(logic [15:0] word);
			logic [7:0] r;
			logic       fb;
			r = 8'h00;
			for (int i = 15; i >= 0; i--) begin
				fb = r[7] ^ word[i];
				r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY[7:0] : 8'h00);
			end
			return r;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
			case (idx)
				REG_FLOW_OFFSET: begin
					offset_reg = val;
				end
				REG_FLOW_SCALE: begin
					scale_reg = val;
				end
				default: begin
				end
			endcase
		endfunction

		function void predict_frame(logic [15:0] word, logic [7:0] chk);
			result_t r;
			logic [7:0] c;
			logic ok;
			logic zero;
			longint diff;
			longint mag;
			longint q;
			c = crc8_of(word);
			ok = (c == chk);
			zero = (scale_reg == 16'd0);
			if (!ok) crc_rejects++;
			if (zero) zero_scale++;
			if (ok && !zero) begin
				diff = longint'(word) - longint'(offset_reg);
				mag = (diff < 0) ? -diff : diff;
				q = (mag << FRAC_BITS_DEF) / longint'(scale_reg);
				if (q > longint'(FLOW_MAX)) q = longint'(FLOW_MAX);
				held_flow = FLOW_W'((diff < 0) ? -q : q);
				converted++;
				if (diff < 0 && q != 0) negatives++;
			end
			r.flow        = held_flow;
			r.crc_ok      = ok;
			r.scale_error = zero;
			r.crc         = c;
			results_due.push_back(r);
		endfunction

		function void check_result(logic [39:0] beat);
			result_t got;
			result_t want;
			got = result_t'(beat[$bits(result_t)-1:0]);
			if (results_due.size() == 0) begin
				$error("result beat %h with no frame outstanding", beat);
				errors++;
				return;
			end
			want = results_due.pop_front();
			checked++;
			if (got.flow !== want.flow) begin
				$error("flow_value: expected %0d, got %0d",
					$signed(want.flow), $signed(got.flow));
				errors++;
			end
			if (got.crc_ok !== want.crc_ok) begin
				$error("crc_ok: expected %0d, got %0d", want.crc_ok, got.crc_ok);
				errors++;
			end
			if (got.scale_error !== want.scale_error) begin
				$error("scale_error: expected %0d, got %0d",
					want.scale_error, got.scale_error);
				errors++;
			end
			if (got.crc !== want.crc) begin
				$error("computed_crc: expected %h, got %h", want.crc, got.crc);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_wdata = '0;
	bit          steady = 1'b0;
	int          settings = 0;

	flow_frame_scoreboard sb = new();

	flow_frame_crc_check_and_scale_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
	end

	// valid stays high across back-to-back beats; gaps drop it
	task automatic send_frame(input logic [15:0] word, input logic [7:0] chk);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {chk, word};
		do @(posedge clk); while (!s_axis_tready);
		sb.predict_frame(word, chk);
	endtask

	task automatic send_good(input logic [15:0] word);
		send_frame(word, flow_frame_scoreboard::crc8_of(word));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// block is idle once the last result is back; a short margin anyway
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.results_due.size() != 0) @(posedge clk);
		repeat (32) @(posedge clk);
	endtask

	task automatic run_directed();
		logic [15:0] w;
		send_good(16'h0000);
		send_good(16'hFFFF);
		send_frame(16'hFFFF, ~flow_frame_scoreboard::crc8_of(16'hFFFF));
		send_frame(16'h1234, flow_frame_scoreboard::crc8_of(16'h1234) ^ 8'h01);
		drain();
		write_reg(REG_FLOW_OFFSET, 16'hFFFF);
		settings++;
		send_good(16'h0000);
		send_good(16'hFFFE);
		send_good(16'hFFFF);
		drain();
		write_reg(REG_FLOW_SCALE, 16'h0000);
		settings++;
		send_good(16'h8000);
		send_frame(16'h8000, flow_frame_scoreboard::crc8_of(16'h8000) ^ 8'h80);
		drain();
		// writes past the register list must leave both registers alone
		write_reg(REG_SPARE_2, 16'h0000);
		write_reg(REG_SPARE_3, 16'hFFFF);
		send_good(16'h4321);
		drain();
		write_reg(REG_FLOW_OFFSET, 16'h8000);
		write_reg(REG_FLOW_SCALE, 16'hFFFF);
		settings++;
		send_good(16'hFFFF);
		send_good(16'h0000);
		send_good(16'h8000);
		drain();
		write_reg(REG_FLOW_SCALE, 16'd3);
		settings++;
		send_good(16'h7FFF);
		w = 16'($urandom);
		send_frame(w, 8'h00);
		w = 16'($urandom);
		send_frame(w, 8'hFF);
		drain();
	endtask

	task automatic run_random_phase(input int ph);
		logic [15:0] off;
		logic [15:0] scl;
		logic [15:0] w;
		logic [7:0]  chk;
		int          k;
		case (ph)
			0: begin
				off = 16'd0;
				scl = 16'd1;
			end
			1: begin
				off = 16'hFFFF;
				scl = 16'hFFFF;
			end
			2: begin
				off = 16'($urandom);
				scl = 16'd0;
			end
			3: begin
				off = 16'h8000;
				scl = 16'($urandom_range(1, 16));
			end
			4: begin
				off = 16'd0;
				scl = 16'd256;
			end
			default: begin
				off = 16'($urandom);
				scl = 16'(($urandom_range(0, 1) != 0) ? $urandom_range(1, 512) : $urandom);
			end
		endcase
		write_reg(REG_FLOW_OFFSET, off);
		write_reg(REG_FLOW_SCALE, scl);
		if ($urandom_range(0, 2) == 0) begin
			write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_3 : REG_SPARE_2,
				16'($urandom));
		end
		settings++;
		steady = (ph == 3);
		repeat (FRAMES_PER_PHASE) begin
			case ($urandom_range(0, 9))
				0: w = 16'h0000;
				1: w = 16'hFFFF;
				2: w = off + 16'($urandom_range(0, 64)) - 16'd32;
				default: w = 16'($urandom);
			endcase
			k = $urandom_range(0, 99);
			chk = flow_frame_scoreboard::crc8_of(w);
			if (k >= 90) chk = 8'($urandom);
			else if (k >= 75) chk = chk ^ (8'h01 << $urandom_range(0, 7));
			send_frame(w, chk);
		end
		steady = 1'b0;
		drain();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		run_directed();
		for (int ph = 0; ph < PHASES; ph++) run_random_phase(ph);
		$display("checked %0d result beats over %0d register settings",
			sb.checked, settings);
		$display("converted %0d (%0d negative), %0d checksum rejects, %0d zero-scale frames",
			sb.converted, sb.negatives, sb.crc_rejects, sb.zero_scale);
		if (sb.errors == 0 && sb.results_due.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- flow_frame_crc_check_and_scale_unit.f -----
rtl/fccs_pkg.sv
rtl/fccs_front.sv
rtl/fccs_queue.sv
rtl/fccs_back.sv
rtl/flow_frame_crc_check_and_scale_unit.sv
tb/flow_frame_crc_check_and_scale_unit_tb.sv
